// ===== rtl/albs_pkg.sv =====
package albs_pkg;

   // Number of LEDs on the string and derived index width
   localparam int LED_COUNT = 64;
   localparam int LED_IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

   // Pixel and slot widths
   localparam int COLOUR_W     = 24;
   localparam int INDEX_W      = 16;
   localparam int PULSE_W      = 8;
   localparam int BITS_PER_LED = 24;
   localparam int BIT_POS_W    = 5;

   // Configuration register indexes
   localparam int CSR_ADDR_W = 1;
   localparam logic [CSR_ADDR_W-1:0] CSR_LONG_PULSE  = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SHORT_PULSE = 1'b1;

   // Request function codes
   typedef enum logic [1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_START = 2'd2,
      FUNC_TICK  = 2'd3
   } func_type;

   // Frame position handed from the sequencer to the datapath
   typedef struct packed {
      logic                 active;
      logic [LED_IDX_W-1:0] led;
      logic [BIT_POS_W-1:0] bit_pos;
      logic                 done_next;
   } slot_type;

   // Bit number within the stored colour for a slot: bytes low to high, each MSB first
   function automatic logic [BIT_POS_W-1:0] slot_bit_index(input logic [BIT_POS_W-1:0] pos);
      return {pos[4:3], ~pos[2:0]};
   endfunction

endpackage

// ===== rtl/albs_pixel_ram.sv =====
module albs_pixel_ram #(
   parameter int DEPTH  = 64,
   parameter int WIDTH  = 24,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port, single registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/albs_frame_seq.sv =====
module albs_frame_seq (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             tick,
   output albs_pkg::slot_type slot
);
   import albs_pkg::*;

   localparam logic [LED_IDX_W-1:0] LED_LAST = LED_IDX_W'(LED_COUNT - 1);
   localparam logic [BIT_POS_W-1:0] BIT_LAST = BIT_POS_W'(BITS_PER_LED - 1);

   logic                 sending_ff, sending_in;
   logic [LED_IDX_W-1:0] led_ff, led_in;
   logic [BIT_POS_W-1:0] bit_ff, bit_in;

   // Next frame position
   always_comb begin
      sending_in = sending_ff;
      led_in     = led_ff;
      bit_in     = bit_ff;
      if (start) begin
         sending_in = 1'b1;
         led_in     = '0;
         bit_in     = '0;
      end else if (tick) begin
         if (sending_ff) begin
            if (bit_ff == BIT_LAST) begin
               bit_in = '0;
               if (led_ff == LED_LAST) begin
                  led_in     = '0;
                  sending_in = 1'b0;
               end else begin
                  led_in = led_ff + LED_IDX_W'(1);
               end
            end else begin
               bit_in = bit_ff + BIT_POS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sending_ff <= 1'b0;
         led_ff     <= '0;
         bit_ff     <= '0;
      end else begin
         sending_ff <= sending_in;
         led_ff     <= led_in;
         bit_ff     <= bit_in;
      end
   end

   // Current slot, plus idle status after this request
   assign slot.active    = sending_ff;
   assign slot.led       = led_ff;
   assign slot.bit_pos   = bit_ff;
   assign slot.done_next = ~sending_in;

`ifndef SYNTHESIS
   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      bit_ff <= BIT_LAST)
      else $error("bit position beyond last slot of an LED");
   a_idle_home: assert property (@(posedge clock) disable iff (reset)
      !sending_ff |-> (led_ff == '0 && bit_ff == '0))
      else $error("idle sequencer not parked at LED 0");
   a_start_arms: assert property (@(posedge clock) disable iff (reset)
      start |=> sending_ff)
      else $error("start did not begin a frame");
`endif

endmodule

// ===== rtl/addressable_led_bit_serializer_core.sv =====
// Addressable LED bit serialiser. Holds one 24-bit colour per LED (LED_COUNT
// entries in a synchronous pixel RAM, black after reset through per-entry
// valid bits, so no clearing pass is needed) and serves four request kinds
// selected by req_tuser: write pixel, read pixel, start frame and bit-slot
// tick. Each tick returns the timer compare value for the next bit of the
// frame (long_pulse for a one, short_pulse for a zero), LEDs in order, each
// LED low byte first, each byte MSB first; after the last LED ticks return 0
// with frame_done set until the next start. Every request gives exactly one
// response. On accept a request issues the pixel RAM read; the registered RAM
// data is then turned into the response once the response register is free,
// and no new request is accepted until that load. The response register
// decouples the two sides.
module addressable_led_bit_serializer_core (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [39:0]                       req_tdata,  // pixel_index[15:0], colour[39:16]
   input  logic [1:0]                        req_tuser,  // func[1:0]
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [39:0]                       rsp_tdata,  // ok[0], read_colour[24:1],
                                                         // pulse_width[32:25], frame_done[33],
                                                         // zero[39:34]
   // configuration
   input  logic                              csr_we,
   input  logic [albs_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [albs_pkg::PULSE_W-1:0]      csr_wdata
);
   import albs_pkg::*;

   // Request fields
   func_type               req_func;
   logic [INDEX_W-1:0]     req_index;
   logic [COLOUR_W-1:0]    req_colour;
   logic                   req_fire;
   logic                   req_in_range;
   logic [LED_IDX_W-1:0]   req_led;
   slot_type               slot;

   assign req_func     = func_type'(req_tuser);
   assign req_index    = req_tdata[INDEX_W-1:0];
   assign req_colour   = req_tdata[INDEX_W +: COLOUR_W];
   assign req_fire     = req_tvalid & req_tready;
   assign req_in_range = (req_index < INDEX_W'(LED_COUNT));
   assign req_led      = req_index[LED_IDX_W-1:0];

   // Configuration registers
   logic [PULSE_W-1:0] long_pulse_ff, short_pulse_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         long_pulse_ff  <= '0;
         short_pulse_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_LONG_PULSE:  long_pulse_ff  <= csr_wdata;
            CSR_SHORT_PULSE: short_pulse_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Frame sequencer
   albs_frame_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (req_fire && req_func == FUNC_START),
      .tick  (req_fire && req_func == FUNC_TICK),
      .slot  (slot)
   );

   // Pixel RAM: write on accept, read pixel or current frame LED on accept
   logic                 ram_we;
   logic [LED_IDX_W-1:0] ram_raddr;
   logic [COLOUR_W-1:0]  ram_rdata;

   assign ram_we    = req_fire && req_func == FUNC_WRITE && req_in_range;
   assign ram_raddr = (req_func == FUNC_READ) ? req_led : slot.led;

   albs_pixel_ram #(
      .DEPTH (LED_COUNT),
      .WIDTH (COLOUR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (req_led),
      .wr_data (req_colour),
      .rd_en   (req_fire),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Written-since-reset flags; an unwritten entry reads as black
   logic [LED_COUNT-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ram_we) begin
         valid_ff[req_led] <= 1'b1;
      end
   end

   // Request details held across the RAM read
   logic                 busy_ff, busy_in;
   func_type             p_func_ff;
   logic                 p_ok_ff;
   logic                 p_active_ff;
   logic                 p_valid_ff;
   logic                 p_done_ff;
   logic [BIT_POS_W-1:0] p_bit_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         p_func_ff   <= req_func;
         p_ok_ff     <= (req_func == FUNC_WRITE || req_func == FUNC_READ) && req_in_range;
         p_active_ff <= slot.active;
         p_valid_ff  <= valid_ff[ram_raddr];
         p_done_ff   <= slot.done_next;
         p_bit_ff    <= slot_bit_index(slot.bit_pos);
      end
   end

   // Response assembly
   logic                rsp_load;
   logic [COLOUR_W-1:0] pix_colour;
   logic [COLOUR_W-1:0] rd_colour;
   logic [PULSE_W-1:0]  pulse;

   assign rsp_load   = busy_ff && (!rsp_tvalid || rsp_tready);
   assign pix_colour = p_valid_ff ? ram_rdata : '0;
   assign rd_colour  = (p_func_ff == FUNC_READ && p_ok_ff) ? pix_colour : '0;

   always_comb begin
      pulse = '0;
      if (p_func_ff == FUNC_TICK && p_active_ff) begin
         pulse = pix_colour[p_bit_ff] ? long_pulse_ff : short_pulse_ff;
      end
   end

   // Busy flag and response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_ok_ff;
   logic [COLOUR_W-1:0] rsp_colour_ff;
   logic [PULSE_W-1:0]  rsp_pulse_ff;
   logic                rsp_done_ff;

   always_comb begin
      busy_in = busy_ff;
      if (req_fire) begin
         busy_in = 1'b1;
      end else if (rsp_load) begin
         busy_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ok_ff     <= p_ok_ff;
         rsp_colour_ff <= rd_colour;
         rsp_pulse_ff  <= pulse;
         rsp_done_ff   <= p_done_ff;
      end
   end

   assign req_tready = ~busy_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_done_ff, rsp_pulse_ff, rsp_colour_ff, rsp_ok_ff};

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> busy_ff)
      else $error("accepted request not held for completion");
   a_pulse_not_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ok_ff && rsp_pulse_ff != '0))
      else $error("pixel access response carries a pulse value");
   a_colour_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_colour_ff != '0) |-> rsp_ok_ff)
      else $error("colour returned without an in-range read");
`endif

endmodule
